// File: src/occupancy_grid_rect_placer_assert.svh
// Assertion macros of the occupancy grid placer top module.
// Depends on nothing; included by the files that check their own logic.
`ifndef OCCUPANCY_GRID_RECT_PLACER_ASSERT_SVH
`define OCCUPANCY_GRID_RECT_PLACER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OGRP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OGRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ogrp_pkg.sv
// Shared types and constants of the occupancy grid rectangle placer.
// Depends on nothing; used by every module of the block.
package ogrp_pkg;

  // Default sizes of the occupancy map.
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  // Field and register widths.
  localparam int COORD_W    = 16;
  localparam int CELL_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int SNAP_W     = 11;
  localparam int PAD_W      = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 11;

  // Divider widths: a padded coordinate needs 17 signed bits, the adjusted
  // quotient 18.
  localparam int DIVIDEND_W = 17;
  localparam int QUOT_W     = 18;
  localparam int DIV_STEPS  = 17;
  localparam int DIV_CNT_W  = 5;

  // Register values after reset.
  localparam logic [COUNT_W-1:0] RST_COLUMN_COUNT = 7'd64;
  localparam logic [COUNT_W-1:0] RST_ROW_COUNT    = 7'd64;
  localparam logic [SNAP_W-1:0]  RST_SNAP         = 11'd128;
  localparam logic [PAD_W-1:0]   RST_PAD          = 10'd0;

  typedef enum logic [1:0] {
    ACT_TEST_FREE    = 2'd0,
    ACT_MARK_GRID    = 2'd1,
    ACT_CONVERT      = 2'd2,
    ACT_CONVERT_MARK = 2'd3
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLUMN_COUNT   = 3'd0,
    REG_ROW_COUNT      = 3'd1,
    REG_SNAP_WIDTH     = 3'd2,
    REG_SNAP_HEIGHT    = 3'd3,
    REG_PAD_HORIZONTAL = 3'd4,
    REG_PAD_VERTICAL   = 3'd5,
    REG_TIGHT_MODE     = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CLAMP,
    ST_PREP,
    ST_WALK,
    ST_FINISH
  } state_t;

  // Input word.
  typedef struct packed {
    action_t                    action;
    logic signed [COORD_W-1:0]  rect_x0;
    logic signed [COORD_W-1:0]  rect_y0;
    logic signed [COORD_W-1:0]  rect_x1;
    logic signed [COORD_W-1:0]  rect_y1;
  } item_t;

  // Result word.
  typedef struct packed {
    logic              is_free;
    logic [CELL_W-1:0] cell_x0;
    logic [CELL_W-1:0] cell_y0;
    logic [CELL_W-1:0] cell_x1;
    logic [CELL_W-1:0] cell_y1;
    logic              range_error;
  } result_t;

  // Port enables of the occupancy map.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } map_ctl_t;

  // Status of the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: src/ogrp_div.sv
// Iterative signed divider with floor or ceiling rounding, one quotient bit
// per cycle. Depends on ogrp_pkg.
module ogrp_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [ogrp_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [ogrp_pkg::SNAP_W-1:0]            divisor,
  input  logic                                   round_up,
  output ogrp_pkg::div_stat_t                    stat,
  output logic signed [ogrp_pkg::QUOT_W-1:0]     quotient
);
  import ogrp_pkg::*;

  logic                         busy;
  logic                         done;
  logic                         neg;
  logic                         up;
  logic [DIV_CNT_W-1:0]         cnt;
  logic [DIVIDEND_W-1:0]        qr;
  logic [SNAP_W-1:0]            rem;
  logic [SNAP_W-1:0]            dvs;
  logic [SNAP_W:0]              rem_sh;
  logic                         take;
  logic                         inexact;
  logic signed [QUOT_W-1:0]     mag_s;
  logic signed [QUOT_W-1:0]     quot_next;
  logic                         launch;

  assign launch  = start && !busy;
  assign rem_sh  = {rem, qr[DIVIDEND_W-1]};
  assign take    = rem_sh >= {1'b0, dvs};
  assign inexact = |rem;
  assign mag_s   = $signed({1'b0, qr});

  // Truncated magnitude quotient, then rounded toward minus infinity, or
  // toward plus infinity when rounding up. Truncation of a negative dividend
  // already rounds up.
  always_comb begin
    if (neg) begin
      quot_next = -mag_s - {{(QUOT_W-1){1'b0}}, ~up & inexact};
    end else begin
      quot_next = mag_s + {{(QUOT_W-1){1'b0}}, up & inexact};
    end
  end

  // Step counter and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (launch) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Restoring division on the magnitude.
  always_ff @(posedge clk) begin
    if (launch) begin
      neg <= dividend[DIVIDEND_W-1];
      up  <= round_up;
      dvs <= divisor;
      rem <= '0;
      qr  <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
    end else if (busy && cnt != '0) begin
      rem <= take ? SNAP_W'(rem_sh - {1'b0, dvs}) : rem_sh[SNAP_W-1:0];
      qr  <= {qr[DIVIDEND_W-2:0], take};
    end
    if (busy && cnt == '0) begin
      quotient <= quot_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: src/ogrp_map.sv
// Occupancy map: one word of row bits per column, synchronous read with a
// registered output and a valid bit per column. Depends on ogrp_pkg.
module ogrp_map #(
  parameter int  MAX_COLUMNS = ogrp_pkg::DEF_MAX_COLUMNS,
  parameter int  MAX_ROWS    = ogrp_pkg::DEF_MAX_ROWS,
  localparam int XW          = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ogrp_pkg::map_ctl_t    ctl,
  input  logic [XW-1:0]         rd_addr,
  input  logic [XW-1:0]         wr_addr,
  input  logic [MAX_ROWS-1:0]   wr_data,
  output logic [MAX_ROWS-1:0]   rd_data
);
  import ogrp_pkg::*;

  logic [MAX_ROWS-1:0]    mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] vld;
  logic [MAX_ROWS-1:0]    rd_word;
  logic                   rd_vld;

  // Valid bits: a column never written since reset reads as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Storage array, one write and one read port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_word <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_word : '0;

endmodule

// File: src/occupancy_grid_rect_placer.sv
// From accept to done, a range error skips the walk, a grid test or mark walks
// its w columns, a conversion runs the four divisions and a conversion that
// marks also walks its w columns. One word at a time; busy stays high
// until the result cycle. The four divisions run one after another on a
// single 17-step divider, and the walk moves one map column per cycle.
// Synchronous reset clears the map through per-column valid bits at once.
module occupancy_grid_rect_placer #(
  parameter int  MAX_COLUMNS = ogrp_pkg::DEF_MAX_COLUMNS,
  parameter int  MAX_ROWS    = ogrp_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  ogrp_pkg::item_t                     item,
  output logic                                done,
  output ogrp_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic [ogrp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ogrp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ogrp_pkg::*;

  `include "occupancy_grid_rect_placer_assert.svh"

  localparam int XW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int RNT_W = $clog2(MAX_ROWS + 1);

  // Configuration registers.
  logic [COUNT_W-1:0] column_count;
  logic [COUNT_W-1:0] row_count;
  logic [SNAP_W-1:0]  snap_width;
  logic [SNAP_W-1:0]  snap_height;
  logic [PAD_W-1:0]   pad_horizontal;
  logic [PAD_W-1:0]   pad_vertical;
  logic               tight_mode;

  state_t state;
  state_t state_next;

  item_t                    item_r;
  logic                     accept;
  logic                     range_err;
  logic [1:0]               div_idx;
  logic signed [QUOT_W-1:0] qv [4];
  logic [XW-1:0]            cx0;
  logic [XW-1:0]            cx1;
  logic [YW-1:0]            cy0;
  logic [YW-1:0]            cy1;
  logic [MAX_ROWS-1:0]      row_mask;
  logic [MAX_ROWS-1:0]      mask_next;
  logic [XW-1:0]            cur_x;
  logic [XW-1:0]            pend_x;
  logic                     walk_more;
  logic                     pend;
  logic                     free_acc;
  logic                     marking;
  logic                     grid_bad;
  result_t                  result_next;

  logic [CNT_W-1:0]         cols;
  logic [RNT_W-1:0]         rows;
  logic signed [QUOT_W-1:0] xmax_s;
  logic signed [QUOT_W-1:0] ymax_s;
  logic signed [QUOT_W-1:0] gx0;
  logic signed [QUOT_W-1:0] gy0;
  logic signed [QUOT_W-1:0] gx1;
  logic signed [QUOT_W-1:0] gy1;

  logic                         div_start;
  div_stat_t                    div_stat;
  logic signed [QUOT_W-1:0]     div_quot;
  logic signed [DIVIDEND_W-1:0] div_dividend;
  logic [SNAP_W-1:0]            div_divisor;
  logic                         div_up;
  logic [COORD_W-1:0]           div_coord;
  logic [PAD_W-1:0]             div_pad;

  map_ctl_t            map_ctl;
  logic [MAX_ROWS-1:0] rd_data;

  // A grid coordinate lies outside when negative or at or beyond the limit.
  function automatic logic coord_bad(logic [COORD_W-1:0] v, logic [COORD_W-1:0] lim);
    return v[COORD_W-1] || (v >= lim);
  endfunction

  assign accept  = start && !busy;
  assign marking = (item_r.action == ACT_MARK_GRID) || (item_r.action == ACT_CONVERT_MARK);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= RST_COLUMN_COUNT;
      row_count      <= RST_ROW_COUNT;
      snap_width     <= RST_SNAP;
      snap_height    <= RST_SNAP;
      pad_horizontal <= RST_PAD;
      pad_vertical   <= RST_PAD;
      tight_mode     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMN_COUNT:   column_count   <= cfg_data[COUNT_W-1:0];
        REG_ROW_COUNT:      row_count      <= cfg_data[COUNT_W-1:0];
        REG_SNAP_WIDTH:     snap_width     <= cfg_data[SNAP_W-1:0];
        REG_SNAP_HEIGHT:    snap_height    <= cfg_data[SNAP_W-1:0];
        REG_PAD_HORIZONTAL: pad_horizontal <= cfg_data[PAD_W-1:0];
        REG_PAD_VERTICAL:   pad_vertical   <= cfg_data[PAD_W-1:0];
        REG_TIGHT_MODE:     tight_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective grid size: zero acts as one, large values stop at the maximum.
  always_comb begin
    if (column_count == '0) begin
      cols = CNT_W'(1);
    end else if (9'(column_count) > 9'(MAX_COLUMNS)) begin
      cols = CNT_W'(MAX_COLUMNS);
    end else begin
      cols = CNT_W'(column_count);
    end
    if (row_count == '0) begin
      rows = RNT_W'(1);
    end else if (8'(row_count) > 8'(MAX_ROWS)) begin
      rows = RNT_W'(MAX_ROWS);
    end else begin
      rows = RNT_W'(row_count);
    end
  end

  assign xmax_s = $signed(QUOT_W'(cols - 1'b1));
  assign ymax_s = $signed(QUOT_W'(rows - 1'b1));

  assign grid_bad = coord_bad(item_r.rect_x0, COORD_W'(cols)) ||
                    coord_bad(item_r.rect_x1, COORD_W'(cols)) ||
                    coord_bad(item_r.rect_y0, COORD_W'(rows)) ||
                    coord_bad(item_r.rect_y1, COORD_W'(rows));

  // Divider operands, one corner coordinate at a time.
  always_comb begin
    case (div_idx)
      2'd0: begin
        div_coord   = item_r.rect_x0;
        div_pad     = pad_horizontal;
        div_divisor = snap_width;
        div_up      = tight_mode;
      end
      2'd1: begin
        div_coord   = item_r.rect_y0;
        div_pad     = pad_vertical;
        div_divisor = snap_height;
        div_up      = tight_mode;
      end
      2'd2: begin
        div_coord   = item_r.rect_x1;
        div_pad     = pad_horizontal;
        div_divisor = snap_width;
        div_up      = 1'b0;
      end
      default: begin
        div_coord   = item_r.rect_y1;
        div_pad     = pad_vertical;
        div_divisor = snap_height;
        div_up      = 1'b0;
      end
    endcase
    if (div_divisor == '0) begin
      div_divisor = SNAP_W'(1);
    end
    div_dividend = $signed({div_coord[COORD_W-1], div_coord}) -
                   $signed({{(DIVIDEND_W-PAD_W){1'b0}}, div_pad});
  end

  // Clamp the converted corners; the end corner never precedes the start.
  always_comb begin
    if (qv[0] > xmax_s) begin
      gx0 = xmax_s;
    end else if (qv[0][QUOT_W-1]) begin
      gx0 = '0;
    end else begin
      gx0 = qv[0];
    end
    if (qv[1] > ymax_s) begin
      gy0 = ymax_s;
    end else if (qv[1][QUOT_W-1]) begin
      gy0 = '0;
    end else begin
      gy0 = qv[1];
    end
    if (qv[2] > xmax_s) begin
      gx1 = xmax_s;
    end else if (qv[2] < gx0) begin
      gx1 = gx0;
    end else begin
      gx1 = qv[2];
    end
    if (qv[3] > ymax_s) begin
      gy1 = ymax_s;
    end else if (qv[3] < gy0) begin
      gy1 = gy0;
    end else begin
      gy1 = qv[3];
    end
  end

  // Row mask of the rectangle; empty when the end row precedes the start.
  always_comb begin
    for (int r = 0; r < MAX_ROWS; r++) begin
      mask_next[r] = (YW'(r) >= cy0) && (YW'(r) <= cy1);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if ((item.action == ACT_TEST_FREE) || (item.action == ACT_MARK_GRID)) begin
            state_next = ST_CHECK;
          end else begin
            state_next = ST_DIV_GO;
          end
        end
      end
      ST_CHECK:    state_next = grid_bad ? ST_FINISH : ST_PREP;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = (div_idx == 2'd3) ? ST_CLAMP : ST_DIV_GO;
        end
      end
      ST_CLAMP: begin
        state_next = (item_r.action == ACT_CONVERT_MARK) ? ST_PREP : ST_FINISH;
      end
      ST_PREP:   state_next = ST_WALK;
      ST_WALK:   state_next = walk_more ? ST_WALK : ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    busy          = (state != ST_IDLE);
    div_start     = (state == ST_DIV_GO);
    map_ctl.rd_en = (state == ST_WALK) && walk_more;
    map_ctl.wr_en = (state == ST_WALK) && pend && marking;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk control: reads are issued one column ahead of the write back.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_more <= 1'b0;
      pend      <= 1'b0;
    end else begin
      pend <= map_ctl.rd_en;
      if (state == ST_PREP) begin
        walk_more <= (cx1 >= cx0);
      end else if (map_ctl.rd_en && cur_x == cx1) begin
        walk_more <= 1'b0;
      end
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= item;
      range_err <= 1'b0;
      div_idx   <= '0;
    end
    if (state == ST_CHECK) begin
      range_err <= grid_bad;
      cx0       <= item_r.rect_x0[XW-1:0];
      cx1       <= item_r.rect_x1[XW-1:0];
      cy0       <= item_r.rect_y0[YW-1:0];
      cy1       <= item_r.rect_y1[YW-1:0];
    end
    if (state == ST_DIV_WAIT && div_stat.done) begin
      qv[div_idx] <= div_quot;
      div_idx     <= div_idx + 1'b1;
    end
    if (state == ST_CLAMP) begin
      cx0 <= gx0[XW-1:0];
      cy0 <= gy0[YW-1:0];
      cx1 <= gx1[XW-1:0];
      cy1 <= gy1[YW-1:0];
    end
    if (state == ST_PREP) begin
      row_mask <= mask_next;
      cur_x    <= cx0;
      free_acc <= 1'b1;
    end
    if (map_ctl.rd_en) begin
      cur_x  <= cur_x + 1'b1;
      pend_x <= cur_x;
    end
    if (state == ST_WALK && pend && !marking) begin
      free_acc <= free_acc & ~|(rd_data & row_mask);
    end
  end

  // Result assembly; unused fields stay zero.
  always_comb begin
    result_next = '0;
    result_next.range_error = range_err;
    if (item_r.action == ACT_TEST_FREE) begin
      result_next.is_free = free_acc && !range_err;
    end
    if ((item_r.action == ACT_CONVERT) || (item_r.action == ACT_CONVERT_MARK)) begin
      result_next.cell_x0 = CELL_W'(cx0);
      result_next.cell_y0 = CELL_W'(cy0);
      result_next.cell_x1 = CELL_W'(cx1);
      result_next.cell_y1 = CELL_W'(cy1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      result <= result_next;
    end
  end

  ogrp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .round_up (div_up),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  ogrp_map #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .ctl     (map_ctl),
    .rd_addr (cur_x),
    .wr_addr (pend_x),
    .wr_data (rd_data | row_mask),
    .rd_data (rd_data)
  );

  // A write back never meets a read of the same column.
  `OGRP_ASSERT_NOW(a_rd_wr_apart, clk, rst, map_ctl.rd_en && map_ctl.wr_en, cur_x != pend_x, "map read and write hit the same column")
  // Only marking actions modify the map.
  `OGRP_ASSERT_NOW(a_write_marks, clk, rst, map_ctl.wr_en, marking && !range_err, "map written outside a marking action")
  // The divider is started only when free.
  `OGRP_ASSERT_NOW(a_div_free, clk, rst, div_start, !div_stat.busy, "divider started while busy")
  // Each word yields a single result cycle.
  `OGRP_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe held for two cycles")

endmodule

// File: tb/ogrp_checker.sv
`timescale 1ns / 100ps
// Checker of the occupancy grid rectangle placer: it watches the command, result and
// register ports, keeps its own occupancy map and predicts each result word.
// Depends on ogrp_pkg for the word types, widths and register indexes.
module ogrp_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  ogrp_pkg::item_t                  item_word,
  input  logic                             done,
  input  ogrp_pkg::result_t                result_word,
  input  logic                             cfg_we,
  input  logic [ogrp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ogrp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               pending,
  output int                               failures
);
  import ogrp_pkg::*;

  localparam int MAX_COLS    = DEF_MAX_COLUMNS;
  localparam int MAX_LINES   = DEF_MAX_ROWS;
  localparam int REPORT_MAX  = 10;

  // Shadow copy of the map (one word of row bits per column) and of the registers.
  logic [MAX_LINES-1:0] occ_map [MAX_COLS];
  logic [COUNT_W-1:0]   col_count;
  logic [COUNT_W-1:0]   row_count;
  logic [SNAP_W-1:0]    snap_w;
  logic [SNAP_W-1:0]    snap_h;
  logic [PAD_W-1:0]     pad_h;
  logic [PAD_W-1:0]     pad_v;
  logic                 tight;

  result_t awaited_results [$];
  int      mismatches;

  // Row bits y0 to y1 inclusive; nothing when the span is empty.
  function automatic logic [MAX_LINES-1:0] span_mask(input int y0, input int y1);
    if (y1 < y0) return '0;
    return ({MAX_LINES{1'b1}} >> (MAX_LINES - 1 - y1)) & ({MAX_LINES{1'b1}} << y0);
  endfunction

  // Division rounded down, or up when asked; truncation already rounds a negative dividend up.
  function automatic int snap_div(input int a, input int b, input bit up);
    int q;
    int r;
    q = a / b;
    r = a % b;
    if (r != 0) begin
      if (up && a > 0) q++;
      if (!up && a < 0) q--;
    end
    return q;
  endfunction

  function automatic int clamp_to(input int v, input int lo, input int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void mark_cells(input int x0, input int y0, input int x1, input int y1);
    logic [MAX_LINES-1:0] m;
    m = span_mask(y0, y1);
    for (int x = x0; x <= x1; x++) occ_map[x] |= m;
  endfunction

  // Works out the result word of one command and applies any marking to the map.
  function automatic result_t place_rect(input item_t w);
    result_t              r;
    int                   cols;
    int                   rows;
    int                   x0, y0, x1, y1;
    int                   sw, sh;
    int                   gx0, gy0, gx1, gy1;
    logic [MAX_LINES-1:0] m;
    r    = '0;
    cols = (col_count == 0) ? 1 : ((int'(col_count) > MAX_COLS) ? MAX_COLS : int'(col_count));
    rows = (row_count == 0) ? 1 : ((int'(row_count) > MAX_LINES) ? MAX_LINES : int'(row_count));
    x0   = w.rect_x0;
    y0   = w.rect_y0;
    x1   = w.rect_x1;
    y1   = w.rect_y1;

    if (w.action == ACT_TEST_FREE || w.action == ACT_MARK_GRID) begin
      // Any corner off the grid flags an error and leaves the map alone.
      if (x0 < 0 || x0 >= cols || x1 < 0 || x1 >= cols ||
          y0 < 0 || y0 >= rows || y1 < 0 || y1 >= rows) begin
        r.range_error = 1'b1;
      end else if (w.action == ACT_TEST_FREE) begin
        m = span_mask(y0, y1);
        r.is_free = 1'b1;
        for (int x = x0; x <= x1; x++) if ((occ_map[x] & m) != '0) r.is_free = 1'b0;
      end else begin
        mark_cells(x0, y0, x1, y1);
      end
    end else begin
      // Canvas to grid: remove the padding, divide by the snap size, then clamp.
      sw  = (snap_w == 0) ? 1 : int'(snap_w);
      sh  = (snap_h == 0) ? 1 : int'(snap_h);
      gx0 = snap_div(x0 - int'(pad_h), sw, tight);
      gy0 = snap_div(y0 - int'(pad_v), sh, tight);
      gx1 = snap_div(x1 - int'(pad_h), sw, 1'b0);
      gy1 = snap_div(y1 - int'(pad_v), sh, 1'b0);
      gx0 = clamp_to(gx0, 0, cols - 1);
      gy0 = clamp_to(gy0, 0, rows - 1);
      gx1 = clamp_to(gx1, gx0, cols - 1);
      gy1 = clamp_to(gy1, gy0, rows - 1);
      if (w.action == ACT_CONVERT_MARK) mark_cells(gx0, gy0, gx1, gy1);
      r.cell_x0 = CELL_W'(gx0);
      r.cell_y0 = CELL_W'(gy0);
      r.cell_x1 = CELL_W'(gx1);
      r.cell_y1 = CELL_W'(gy1);
    end
    return r;
  endfunction

  // Register writes, result comparison and prediction of accepted words.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (occ_map[i]) occ_map[i] = '0;
      col_count = RST_COLUMN_COUNT;
      row_count = RST_ROW_COUNT;
      snap_w    = RST_SNAP;
      snap_h    = RST_SNAP;
      pad_h     = RST_PAD;
      pad_v     = RST_PAD;
      tight     = 1'b0;
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_COLUMN_COUNT:   col_count = cfg_data[COUNT_W-1:0];
          REG_ROW_COUNT:      row_count = cfg_data[COUNT_W-1:0];
          REG_SNAP_WIDTH:     snap_w    = cfg_data[SNAP_W-1:0];
          REG_SNAP_HEIGHT:    snap_h    = cfg_data[SNAP_W-1:0];
          REG_PAD_HORIZONTAL: pad_h     = cfg_data[PAD_W-1:0];
          REG_PAD_VERTICAL:   pad_v     = cfg_data[PAD_W-1:0];
          REG_TIGHT_MODE:     tight     = cfg_data[0];
          default: ;
        endcase
      end

      // A result word belongs to an earlier command, so compare before predicting.
      if (done) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result word: free=%0d cells=(%0d,%0d)-(%0d,%0d) err=%0d",
                     result_word.is_free, result_word.cell_x0, result_word.cell_y0,
                     result_word.cell_x1, result_word.cell_y1, result_word.range_error);
        end else begin
          want = awaited_results.pop_front();
          if (result_word.is_free !== want.is_free || result_word.cell_x0 !== want.cell_x0 ||
              result_word.cell_y0 !== want.cell_y0 || result_word.cell_x1 !== want.cell_x1 ||
              result_word.cell_y1 !== want.cell_y1 ||
              result_word.range_error !== want.range_error) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"result word mismatch: expected free=%0d cells=(%0d,%0d)-(%0d,%0d)",
                        " err=%0d, got free=%0d cells=(%0d,%0d)-(%0d,%0d) err=%0d"},
                       want.is_free, want.cell_x0, want.cell_y0, want.cell_x1,
                       want.cell_y1, want.range_error,
                       result_word.is_free, result_word.cell_x0, result_word.cell_y0,
                       result_word.cell_x1, result_word.cell_y1, result_word.range_error);
          end
        end
      end

      if (start && !busy) awaited_results.push_back(place_rect(item_word));
    end
    pending  <= awaited_results.size();
    failures <= mismatches + awaited_results.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the occupancy grid rectangle placer testbench: clock, reset, command and
// register stimulus, and the final verdict. Depends on ogrp_pkg and ogrp_checker.
module tb_top;
  import ogrp_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 200;
  localparam int WORDS_PER_PHASE = 88;
  localparam int MAX_GAP         = 60;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  logic                   busy;
  item_t                  item_word = '0;
  logic                   done;
  result_t                result_word;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  int                     pending;
  int                     failures;
  int                     cycle_count = 0;

  // Effective grid settings, used only to aim the random commands.
  int grid_cols = DEF_MAX_COLUMNS;
  int grid_rows = DEF_MAX_ROWS;
  int snap_x    = 128;
  int snap_y    = 128;
  int pad_x     = 0;
  int pad_y     = 0;
  int idle_pct  = 0;

  always #4 clk = ~clk;

  occupancy_grid_rect_placer u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item_word),
    .done      (done),
    .result    (result_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ogrp_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item_word   (item_word),
    .done        (done),
    .result_word (result_word),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pending     (pending),
    .failures    (failures)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Random idle cycles after a word has been taken.
  task automatic pause_sender();
    int n;
    n = 0;
    while (n < MAX_GAP && $urandom_range(99) < idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present a command word and hold it until the block takes it.
  task automatic send_word(input item_t w);
    start     <= 1'b1;
    item_word <= w;
    do @(posedge clk); while (busy);
    pause_sender();
  endtask

  // Stop sending and wait until every result word has come back.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  // One register write; the bits above the register's width carry random junk.
  task automatic write_reg(input cfg_reg_t idx, input int width, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (CFG_DATA_W'($urandom) << width) | CFG_DATA_W'(value & ((1 << width) - 1));
    @(posedge clk);
  endtask

  task automatic apply_setting(input int cols, rows, sw, sh, ph, pv, tight);
    write_reg(REG_COLUMN_COUNT, COUNT_W, cols);
    write_reg(REG_ROW_COUNT, COUNT_W, rows);
    write_reg(REG_SNAP_WIDTH, SNAP_W, sw);
    write_reg(REG_SNAP_HEIGHT, SNAP_W, sh);
    write_reg(REG_PAD_HORIZONTAL, PAD_W, ph);
    write_reg(REG_PAD_VERTICAL, PAD_W, pv);
    write_reg(REG_TIGHT_MODE, 1, tight);
    cfg_we    <= 1'b0;
    grid_cols = (cols == 0) ? 1 : ((cols > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : cols);
    grid_rows = (rows == 0) ? 1 : ((rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows);
    snap_x    = (sw == 0) ? 1 : sw;
    snap_y    = (sh == 0) ? 1 : sh;
    pad_x     = ph;
    pad_y     = pv;
  endtask

  // Grid span mostly inside the grid, sometimes empty or with a corner off it.
  function automatic void grid_pair(input int cnt, input int span, output int a, output int b);
    a = int'($urandom_range(cnt - 1));
    b = a + int'($urandom_range(span));
    if ($urandom_range(15) == 0) b = a - 1;
    if (b >= cnt && $urandom_range(7) != 0) b = cnt - 1;
    if ($urandom_range(19) == 0) begin
      case ($urandom_range(3))
        0: a = -1;
        1: b = cnt;
        2: a = -32768;
        default: b = 32767;
      endcase
    end
  endfunction

  // Canvas span around the grid, a little beyond either edge and off the snap points.
  function automatic void canvas_pair(input int pad, snap, cnt, span, output int a, b);
    int k;
    k = int'($urandom_range(cnt + 7)) - 4;
    a = pad + k * snap + int'($urandom_range(2 * snap)) - snap;
    b = a + int'($urandom_range(span * snap)) - snap / 2;
  endfunction

  function automatic item_t random_word();
    item_t w;
    int    pick;
    int    x0, y0, x1, y1;
    pick = $urandom_range(99);
    if (pick < 40)      w.action = ACT_TEST_FREE;
    else if (pick < 55) w.action = ACT_MARK_GRID;
    else if (pick < 80) w.action = ACT_CONVERT;
    else                w.action = ACT_CONVERT_MARK;

    // Marks stay small so that the map does not fill up early.
    if (w.action == ACT_TEST_FREE || w.action == ACT_MARK_GRID) begin
      grid_pair(grid_cols, (w.action == ACT_MARK_GRID) ? 2 : 12, x0, x1);
      grid_pair(grid_rows, (w.action == ACT_MARK_GRID) ? 2 : 12, y0, y1);
    end else begin
      canvas_pair(pad_x, snap_x, grid_cols, (w.action == ACT_CONVERT) ? 6 : 1, x0, x1);
      canvas_pair(pad_y, snap_y, grid_rows, (w.action == ACT_CONVERT) ? 6 : 1, y0, y1);
    end

    // Now and then raw coordinates, except where they would mark most of the map.
    if (w.action != ACT_CONVERT_MARK && $urandom_range(9) == 0) begin
      x0 = $urandom;
      y0 = $urandom;
      x1 = $urandom;
      y1 = $urandom;
    end
    w.rect_x0 = COORD_W'(x0);
    w.rect_y0 = COORD_W'(y0);
    w.rect_x1 = COORD_W'(x1);
    w.rect_y1 = COORD_W'(y1);
    return w;
  endfunction

  function automatic item_t make_word(input action_t a, input int x0, y0, x1, y1);
    item_t w;
    w.action  = a;
    w.rect_x0 = COORD_W'(x0);
    w.rect_y0 = COORD_W'(y0);
    w.rect_x1 = COORD_W'(x1);
    w.rect_y1 = COORD_W'(y1);
    return w;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_word(random_word());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed words on the reset settings: whole grid, single corners, empty
    // rectangles, coordinates off the grid and canvas extremes.
    send_word(make_word(ACT_TEST_FREE, 0, 0, 63, 63));
    send_word(make_word(ACT_MARK_GRID, 0, 0, 0, 0));
    send_word(make_word(ACT_TEST_FREE, 0, 0, 63, 63));
    send_word(make_word(ACT_TEST_FREE, 1, 1, 63, 63));
    send_word(make_word(ACT_MARK_GRID, 63, 63, 63, 63));
    send_word(make_word(ACT_TEST_FREE, 62, 0, 63, 63));
    send_word(make_word(ACT_TEST_FREE, 5, 0, 4, 63));
    send_word(make_word(ACT_MARK_GRID, 10, 20, 10, 19));
    send_word(make_word(ACT_TEST_FREE, 10, 19, 10, 20));
    send_word(make_word(ACT_TEST_FREE, -1, 0, 0, 0));
    send_word(make_word(ACT_MARK_GRID, 0, 0, 64, 0));
    send_word(make_word(ACT_TEST_FREE, 0, -32768, 0, 0));
    send_word(make_word(ACT_MARK_GRID, 0, 0, 0, 32767));
    send_word(make_word(ACT_TEST_FREE, 32767, 0, -32768, 0));
    send_word(make_word(ACT_CONVERT, -32768, -32768, 32767, 32767));
    send_word(make_word(ACT_CONVERT, -1, -129, 127, 128));
    send_word(make_word(ACT_CONVERT_MARK, 256, 384, 511, 639));
    send_word(make_word(ACT_TEST_FREE, 2, 3, 3, 4));
    send_word(make_word(ACT_CONVERT, 1000, 1000, 0, 0));
    send_word(make_word(ACT_CONVERT_MARK, -200, 8191, -100, 8192));
    send_word(make_word(ACT_TEST_FREE, 0, 62, 0, 63));

    // Random phases; after the first, each on a new setting written while the block is idle.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1: apply_setting(64, 64, 1, 1, 0, 0, 1);
          2: apply_setting(1, 1, 1024, 1024, 1023, 1023, 0);
          3: apply_setting(0, 0, 0, 0, 0, 0, 1);
          4: apply_setting(127, 100, 7, 13, 5, 9, 0);
          default: apply_setting($urandom_range(64, 1), $urandom_range(64, 1),
                                 $urandom_range(1024, 1), $urandom_range(1024, 1),
                                 $urandom_range(1023), $urandom_range(1023),
                                 $urandom_range(1));
        endcase
      end
      idle_pct = (phase % 4 == 1) ? 83 : ((phase % 4 == 3) ? 35 : 0);
      run_random(WORDS_PER_PHASE);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
